FILE: src/csu_pkg.sv
// Package with the shared widths and types of the cosine similarity unit.
`timescale 1ns / 1ps
package csu_pkg;
   localparam int unsigned MaxLenDefault = 512;
   localparam int unsigned ElemWidth = 16;
   localparam int unsigned DotWidth = 41;
   localparam int unsigned NormWidth = 40;
   localparam int unsigned ProdWidth = 2 * NormWidth;
   localparam int unsigned RootWidth = NormWidth;

   // Finished sums of one vector pair, handed from the front to the back.
   typedef struct packed {
      logic [DotWidth-1:0]  dot;
      logic [NormWidth-1:0] norm_a;
      logic [NormWidth-1:0] norm_b;
   } sums_type;
endpackage

FILE: src/cosine_similarity_unit.sv
// Elements enter at one per cycle while req_full is low; the back end handles
// one vector at a time (four-step norm product, 40-step root, 56-step division,
// then an output state held until popped), and a queue of two entries (four when
// MAX_LEN is below 64) lets the front keep accumulating the next vector meanwhile.
// Reset clears the accumulators, the queue and the back-end state.
`timescale 1ns / 1ps
module cosine_similarity_unit #(
   parameter int unsigned MAX_LEN = csu_pkg::MaxLenDefault
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_push,
   output logic                                 req_full,
   input  logic signed [csu_pkg::ElemWidth-1:0] req_element_a,
   input  logic signed [csu_pkg::ElemWidth-1:0] req_element_b,
   input  logic                                 req_is_last,
   output logic                                 rsp_empty,
   input  logic                                 rsp_pop,
   output logic signed [csu_pkg::ElemWidth-1:0] rsp_similarity
);
   // Queue depth grows for short vectors so the back end stays fed.
   localparam int unsigned QDepth = (MAX_LEN < 64) ? 4 : 2;
   logic f_push, f_full, b_pop, b_empty;
   csu_pkg::sums_type f_data, b_data;

   csu_front u_front (
      .clock, .reset, .req_push, .req_full, .req_element_a, .req_element_b,
      .req_is_last, .q_push(f_push), .q_full(f_full), .q_data(f_data)
   );

   csu_queue #(.Depth(QDepth)) u_queue (
      .clock, .reset, .push(f_push), .full(f_full), .wdata(f_data),
      .pop(b_pop), .empty(b_empty), .rdata(b_data)
   );

   csu_back u_back (
      .clock, .reset, .q_empty(b_empty), .q_pop(b_pop), .q_data(b_data),
      .rsp_empty, .rsp_pop, .rsp_similarity
   );
endmodule

FILE: src/csu_front.sv
// Front end: accumulates the dot product and both squared norms per vector.
`timescale 1ns / 1ps
module csu_front (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_push,
   output logic                                 req_full,
   input  logic signed [csu_pkg::ElemWidth-1:0] req_element_a,
   input  logic signed [csu_pkg::ElemWidth-1:0] req_element_b,
   input  logic                                 req_is_last,
   output logic                                 q_push,
   input  logic                                 q_full,
   output csu_pkg::sums_type                    q_data
);
   logic [csu_pkg::DotWidth-1:0]  dot_ff, dot_in;
   logic [csu_pkg::NormWidth-1:0] na_ff, na_in, nb_ff, nb_in;
   logic signed [31:0] pab, paa, pbb;
   logic take;

   // Every element waits while the queue is full, so a last element always finds a slot.
   assign req_full = q_full;
   assign take = req_push && !q_full;

   // Element products, exact in 32 bits.
   assign pab = req_element_a * req_element_b;
   assign paa = req_element_a * req_element_a;
   assign pbb = req_element_b * req_element_b;

   // Sums including the current element, wrapping at their widths.
   assign dot_in = dot_ff + {{(csu_pkg::DotWidth-32){pab[31]}}, pab};
   assign na_in = na_ff + {{(csu_pkg::NormWidth-32){1'b0}}, paa};
   assign nb_in = nb_ff + {{(csu_pkg::NormWidth-32){1'b0}}, pbb};

   assign q_push = take && req_is_last;
   assign q_data = '{dot: dot_in, norm_a: na_in, norm_b: nb_in};

   always_ff @(posedge clock) begin
      if (reset || (take && req_is_last)) begin
         dot_ff <= '0;
         na_ff <= '0;
         nb_ff <= '0;
      end else if (take) begin
         dot_ff <= dot_in;
         na_ff <= na_in;
         nb_ff <= nb_in;
      end
   end
endmodule

FILE: src/csu_queue.sv
// Short queue of finished sums between the front and the back.
`timescale 1ns / 1ps
module csu_queue #(
   parameter int unsigned Depth = 2
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   output logic              full,
   input  csu_pkg::sums_type wdata,
   input  logic              pop,
   output logic              empty,
   output csu_pkg::sums_type rdata
);
   localparam int unsigned Aw = (Depth > 1) ? $clog2(Depth) : 1;
   csu_pkg::sums_type mem_ff [Depth];
   logic [Aw-1:0] wp_ff, rp_ff;
   logic [Aw:0] cnt_ff;

   assign full = (cnt_ff == (Aw+1)'(Depth));
   assign empty = (cnt_ff == '0);
   assign rdata = mem_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (push && !full) mem_ff[wp_ff] <= wdata;
   end

   // Pointer and fill count upkeep.
   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0;
         rp_ff <= '0;
         cnt_ff <= '0;
      end else begin
         if (push && !full)
            wp_ff <= (wp_ff == Aw'(Depth-1)) ? '0 : wp_ff + 1'b1;
         if (pop && !empty)
            rp_ff <= (rp_ff == Aw'(Depth-1)) ? '0 : rp_ff + 1'b1;
         cnt_ff <= cnt_ff + (Aw+1)'(push && !full) - (Aw+1)'(pop && !empty);
      end
   end
endmodule

FILE: src/csu_back.sv
// Back end: norm product, square root, division and clamp, one vector at a time.
`timescale 1ns / 1ps
module csu_back (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 q_empty,
   output logic                                 q_pop,
   input  csu_pkg::sums_type                    q_data,
   output logic                                 rsp_empty,
   input  logic                                 rsp_pop,
   output logic signed [csu_pkg::ElemWidth-1:0] rsp_similarity
);
   localparam logic [2:0] StIdle = 3'd0;
   localparam logic [2:0] StMul  = 3'd1;
   localparam logic [2:0] StRoot = 3'd2;
   localparam logic [2:0] StDiv  = 3'd3;
   localparam logic [2:0] StOut  = 3'd4;
   localparam int unsigned Nw = csu_pkg::NormWidth;
   localparam int unsigned Rw = csu_pkg::RootWidth;
   localparam int unsigned Mw = csu_pkg::DotWidth + 15; // shifted magnitude
   localparam int unsigned Hw = Nw / 2;

   logic [2:0] st_ff, st_in;
   logic [5:0] cnt_ff, cnt_in;
   logic [Nw-1:0] na_ff, nb_ff;
   logic [csu_pkg::ProdWidth-1:0] prod_ff, prod_in;
   logic [Rw:0] rem_ff, rem_in;     // root remainder
   logic [Rw-1:0] root_ff, root_in;
   logic [Mw-1:0] num_ff, num_in;   // dividend shifting into quotient
   logic [Rw:0] drem_ff, drem_in;   // division remainder
   logic neg_ff, neg_in, zero_ff, zero_in;
   logic signed [csu_pkg::ElemWidth-1:0] res_in;
   logic [Hw-1:0] pa, pb;
   logic [2*Hw-1:0] pp;
   logic [Rw+2:0] rtrial;
   logic [Rw+2:0] rshift;
   logic [Rw+2:0] rroot;
   logic [Rw:0] dshift;
   logic [csu_pkg::DotWidth-1:0] mag;

   assign q_pop = (st_ff == StIdle) && !q_empty;
   assign rsp_empty = (st_ff != StOut);
   assign rsp_similarity = res_in;
   assign mag = q_data.dot[csu_pkg::DotWidth-1] ? -q_data.dot : q_data.dot;

   // Partial product for the norm product: four 20x20 steps.
   assign pa = cnt_ff[1] ? na_ff[Nw-1:Hw] : na_ff[Hw-1:0];
   assign pb = cnt_ff[0] ? nb_ff[Nw-1:Hw] : nb_ff[Hw-1:0];
   assign pp = pa * pb;

   // One root bit per step from the two top bits of the product.
   assign rshift = {rem_ff, prod_ff[csu_pkg::ProdWidth-1 -: 2]};
   assign rroot = {1'b0, root_ff, 2'b01};
   assign rtrial = rshift - rroot;
   assign dshift = {drem_ff[Rw-1:0], num_ff[Mw-1]};

   always_comb begin
      st_in = st_ff;
      cnt_in = cnt_ff;
      prod_in = prod_ff;
      rem_in = rem_ff;
      root_in = root_ff;
      num_in = num_ff;
      drem_in = drem_ff;
      neg_in = neg_ff;
      zero_in = zero_ff;
      res_in = '0;
      unique case (st_ff)
         StIdle: begin
            if (!q_empty) begin
               st_in = StMul;
               cnt_in = '0;
               prod_in = '0;
               neg_in = q_data.dot[csu_pkg::DotWidth-1];
               zero_in = (q_data.norm_a == '0) || (q_data.norm_b == '0);
               num_in = {mag, 15'd0};
            end
         end
         StMul: begin
            prod_in = prod_ff + ({{(csu_pkg::ProdWidth-2*Hw){1'b0}}, pp}
                      << (Hw * (32'(cnt_ff[1]) + 32'(cnt_ff[0]))));
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == 6'd3) begin
               st_in = StRoot;
               cnt_in = '0;
               rem_in = '0;
               root_in = '0;
            end
         end
         StRoot: begin
            prod_in = prod_ff << 2;
            if (rshift >= rroot) begin
               rem_in = rtrial[Rw:0];
               root_in = {root_ff[Rw-2:0], 1'b1};
            end else begin
               rem_in = rshift[Rw:0];
               root_in = {root_ff[Rw-2:0], 1'b0};
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == 6'(Rw-1)) begin
               st_in = StDiv;
               cnt_in = '0;
               drem_in = '0;
            end
         end
         StDiv: begin
            if (dshift >= {1'b0, root_ff}) begin
               drem_in = dshift - {1'b0, root_ff};
               num_in = {num_ff[Mw-2:0], 1'b1};
            end else begin
               drem_in = dshift;
               num_in = {num_ff[Mw-2:0], 1'b0};
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == 6'(Mw-1)) st_in = StOut;
         end
         StOut: begin
            if (zero_ff || root_ff == '0) res_in = '0;
            else if (neg_ff)
               res_in = (num_ff > Mw'(32768)) ? 16'sh8000 : -$signed(num_ff[15:0]);
            else
               res_in = (num_ff > Mw'(32767)) ? 16'sh7fff : $signed(num_ff[15:0]);
            if (rsp_pop) st_in = StIdle;
         end
         default: st_in = StIdle;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= StIdle;
         cnt_ff <= '0;
      end else begin
         st_ff <= st_in;
         cnt_ff <= cnt_in;
      end
   end

   // Operand capture and datapath registers.
   always_ff @(posedge clock) begin
      if (st_ff == StIdle && !q_empty) begin
         na_ff <= q_data.norm_a;
         nb_ff <= q_data.norm_b;
      end
      prod_ff <= prod_in;
      rem_ff <= rem_in;
      root_ff <= root_in;
      num_ff <= num_in;
      drem_ff <= drem_in;
      neg_ff <= neg_in;
      zero_ff <= zero_in;
   end
endmodule

FILE: test/testbench.sv
// Self-checking testbench for the cosine similarity unit.
`timescale 1ns / 1ps
module testbench;
   typedef struct {
      shortint a;
      shortint b;
      bit      last;
      bit      known;
      shortint sim;
   } stim_row_type;

   localparam int NumRows = 16;
   localparam int TargetItems = 850;
   localparam int CycleLimit = 400000;
   localparam int DrainCycles = 200;

   logic                                 clock;
   logic                                 reset;
   logic                                 req_push;
   logic                                 req_full;
   logic signed [csu_pkg::ElemWidth-1:0] req_element_a;
   logic signed [csu_pkg::ElemWidth-1:0] req_element_b;
   logic                                 req_is_last;
   logic                                 rsp_empty;
   logic                                 rsp_pop;
   logic signed [csu_pkg::ElemWidth-1:0] rsp_similarity;

   // Predictor state: running sums of the vector pair in progress.
   logic signed [csu_pkg::DotWidth-1:0] dot_acc;
   logic [csu_pkg::NormWidth-1:0]       norm_a_acc;
   logic [csu_pkg::NormWidth-1:0]       norm_b_acc;

   shortint      similarity_queue[$];
   bit           typed_known_queue[$];
   shortint      typed_sim_queue[$];
   stim_row_type stim_rows[NumRows];
   int           error_count;
   int           cycle_count;
   int           items_sent;

   cosine_similarity_unit uut (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_element_a  (req_element_a),
      .req_element_b  (req_element_b),
      .req_is_last    (req_is_last),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_similarity (rsp_similarity)
   );

   // Clock generation.
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Cosine of the finished sums: dot scaled by 2^15 over the floor root of
   // the norm product, truncated and saturated to Q1.15.
   function automatic shortint cosine_of(logic signed [csu_pkg::DotWidth-1:0] dot,
                                         logic [csu_pkg::NormWidth-1:0] na,
                                         logic [csu_pkg::NormWidth-1:0] nb);
      logic [csu_pkg::ProdWidth-1:0] prod;
      logic [csu_pkg::ProdWidth-1:0] square;
      logic [csu_pkg::RootWidth-1:0] root;
      logic [csu_pkg::RootWidth-1:0] cand;
      logic [csu_pkg::DotWidth-1:0]  mag;
      logic [63:0]                   quot;
      bit                            neg;
      if (na == 0 || nb == 0) begin
         return 0;
      end
      prod = {{csu_pkg::NormWidth{1'b0}}, na} * {{csu_pkg::NormWidth{1'b0}}, nb};
      root = '0;
      for (int k = csu_pkg::RootWidth - 1; k >= 0; k--) begin
         cand = root | ({{(csu_pkg::RootWidth-1){1'b0}}, 1'b1} << k);
         square = {{csu_pkg::RootWidth{1'b0}}, cand} * {{csu_pkg::RootWidth{1'b0}}, cand};
         if (square <= prod) begin
            root = cand;
         end
      end
      if (root == 0) begin
         return 0;
      end
      neg = dot[csu_pkg::DotWidth-1];
      mag = neg ? -dot : dot;
      quot = ({{(64-csu_pkg::DotWidth){1'b0}}, mag} << 15)
             / {{(64-csu_pkg::RootWidth){1'b0}}, root};
      if (neg) begin
         return (quot > 64'd32768) ? -16'sd32768 : -shortint'(quot);
      end
      return (quot > 64'd32767) ? 16'sd32767 : shortint'(quot);
   endfunction

   // Track accepted input transactions and predict results.
   always @(posedge clock) begin
      logic signed [csu_pkg::DotWidth-1:0]  dot_next;
      logic [csu_pkg::NormWidth-1:0]        na_next;
      logic [csu_pkg::NormWidth-1:0]        nb_next;
      logic signed [csu_pkg::DotWidth-1:0]  prod_ab;
      logic signed [csu_pkg::NormWidth-1:0] prod_aa;
      logic signed [csu_pkg::NormWidth-1:0] prod_bb;
      shortint                              predicted;
      if (reset) begin
         dot_acc <= '0;
         norm_a_acc <= '0;
         norm_b_acc <= '0;
      end else if (req_push && !req_full) begin
         prod_ab = req_element_a * req_element_b;
         prod_aa = req_element_a * req_element_a;
         prod_bb = req_element_b * req_element_b;
         dot_next = dot_acc + prod_ab;
         na_next = norm_a_acc + prod_aa;
         nb_next = norm_b_acc + prod_bb;
         if (req_is_last) begin
            predicted = cosine_of(dot_next, na_next, nb_next);
            if (typed_known_queue.pop_front()) begin
               predicted = typed_sim_queue.pop_front();
            end else begin
               void'(typed_sim_queue.pop_front());
            end
            similarity_queue = {similarity_queue, predicted};
            dot_acc <= '0;
            norm_a_acc <= '0;
            norm_b_acc <= '0;
         end else begin
            dot_acc <= dot_next;
            norm_a_acc <= na_next;
            norm_b_acc <= nb_next;
         end
      end
   end

   // Compare each accepted result transaction with the oldest prediction.
   always @(posedge clock) begin
      shortint wanted;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (similarity_queue.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual %0d",
                     $time, rsp_similarity);
            error_count++;
         end else begin
            wanted = similarity_queue.pop_front();
            if (rsp_similarity !== wanted) begin
               $display("%0t: similarity expected %0d, actual %0d",
                        $time, wanted, rsp_similarity);
               error_count++;
            end
         end
      end
   end

   // Receiver: random stalls, a quiet stretch, and one long hold-off.
   initial begin
      int rx_cycles;
      rx_cycles = 0;
      rsp_pop <= 1'b0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         rx_cycles++;
         if (rx_cycles >= 600 && rx_cycles < 1400) begin
            rsp_pop <= 1'b0;
         end else if (rx_cycles >= 3000 && rx_cycles < 5000) begin
            rsp_pop <= 1'b1;
         end else begin
            rsp_pop <= ($urandom_range(99) >= 9);
         end
      end
   end

   // Run limit.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("cosine_similarity_unit: mismatch");
         $finish;
      end
   end

   // Send one element pair, with an occasional one-cycle gap first.
   task automatic send_pair(shortint a, shortint b, bit last, bit known, shortint sim,
                            bit quiet);
      if (!quiet && $urandom_range(99) < 9) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      if (last) begin
         typed_known_queue = {typed_known_queue, known};
         typed_sim_queue = {typed_sim_queue, sim};
      end
      req_push <= 1'b1;
      req_element_a <= a;
      req_element_b <= b;
      req_is_last <= last;
      do @(posedge clock); while (req_full);
      items_sent++;
   endtask

   function automatic shortint pick_element();
      case ($urandom_range(5))
         0: return -16'sd32768;
         1: return 16'sd32767;
         2: return 0;
         3: return shortint'($urandom_range(0, 64)) - 16'sd32;
         default: return shortint'($urandom);
      endcase
   endfunction

   // Stimulus.
   initial begin
      int      len;
      bit      quiet;
      bit      zero_a;
      shortint ea;
      error_count = 0;
      cycle_count = 0;
      items_sent = 0;
      reset <= 1'b1;
      req_push <= 1'b0;
      req_element_a <= '0;
      req_element_b <= '0;
      req_is_last <= 1'b0;

      // Full-scale extremes, zero norms, and short vectors.
      stim_rows[0]  = '{16'sd32767, 16'sd32767, 1, 1, 16'sd32767};
      stim_rows[1]  = '{-16'sd32768, -16'sd32768, 1, 1, 16'sd32767};
      stim_rows[2]  = '{16'sd32767, -16'sd32768, 1, 1, -16'sd32768};
      stim_rows[3]  = '{-16'sd32768, 16'sd32767, 1, 1, -16'sd32768};
      stim_rows[4]  = '{16'sd0, 16'sd5, 1, 1, 16'sd0};
      stim_rows[5]  = '{16'sd0, 16'sd0, 1, 1, 16'sd0};
      stim_rows[6]  = '{-16'sd1, 16'sd0, 1, 1, 16'sd0};
      stim_rows[7]  = '{16'sd1, -16'sd1, 1, 1, -16'sd32768};
      stim_rows[8]  = '{16'sd1, 16'sd1, 0, 0, 16'sd0};
      stim_rows[9]  = '{16'sd2, 16'sd2, 0, 0, 16'sd0};
      stim_rows[10] = '{16'sd3, 16'sd3, 1, 0, 16'sd0};
      stim_rows[11] = '{16'sd100, -16'sd50, 0, 0, 16'sd0};
      stim_rows[12] = '{-16'sd200, 16'sd300, 0, 0, 16'sd0};
      stim_rows[13] = '{16'sd12345, -16'sd23456, 1, 0, 16'sd0};
      stim_rows[14] = '{16'sd21845, -16'sd21846, 0, 0, 16'sd0};
      stim_rows[15] = '{-16'sd1, 16'sd1, 1, 0, 16'sd0};

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (stim_rows[i]) begin
         send_pair(stim_rows[i].a, stim_rows[i].b, stim_rows[i].last,
                   stim_rows[i].known, stim_rows[i].sim, 0);
      end

      // Random vectors, with at most one full-scale vector longer than MAX_LEN.
      while (items_sent < TargetItems) begin
         quiet = (items_sent > 750 && items_sent < 820);
         if (items_sent > 100 && items_sent < 120) begin
            for (int i = 0; i < 600; i++) begin
               send_pair(-16'sd32768, -16'sd32768, i == 599, 0, 0, 1);
            end
         end
         len = ($urandom_range(9) == 0) ? $urandom_range(1, 64) : $urandom_range(1, 12);
         zero_a = ($urandom_range(19) == 0);
         for (int i = 0; i < len; i++) begin
            ea = zero_a ? 16'sd0 : pick_element();
            send_pair(ea, pick_element(), i == len - 1, 0, 0, quiet);
         end
      end
      req_push <= 1'b0;

      // Drain outstanding results.
      while (similarity_queue.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      if (error_count == 0) begin
         $display("cosine_similarity_unit: match");
      end else begin
         $display("cosine_similarity_unit: mismatch");
      end
      $finish;
   end
endmodule
